// ===== src/lbfc_pkg.sv =====
// ============================================================================
// lbfc_pkg
// Shared types, constants and helper functions for the letter bigram counter.
// ============================================================================
`default_nettype none

package lbfc_pkg;

  // Counter width (range 8..32); result fields stay 24 bits wide.
  localparam int COUNT_WIDTH = 24;
  localparam int OUT_WIDTH   = 24;
  localparam int SYM_W       = 5;
  localparam int PAIR_ADDR_W = 2 * SYM_W;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [OUT_WIDTH-1:0]   out_count_t;
  typedef logic [SYM_W-1:0]       sym_t;
  typedef logic [PAIR_ADDR_W-1:0] pair_addr_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam sym_t SYM_IE        = 5'd5;
  localparam sym_t SYM_SOFT_SIGN = 5'd27;
  localparam sym_t SYM_SPACE     = 5'd31;
  localparam sym_t HARD_SIGN_POS = 5'd26;

  localparam logic [7:0] BYTE_YO_UPPER  = 8'hA8;
  localparam logic [7:0] BYTE_YO_LOWER  = 8'hB8;
  localparam logic [7:0] BYTE_LETTER_LO = 8'hC0;

  localparam logic [1:0] PAIR_STEP_DISJOINT = 2'd2;

  typedef enum logic [1:0] {
    OP_FEED        = 2'd0,
    OP_READ_LETTER = 2'd1,
    OP_READ_PAIR   = 2'd2,
    OP_CLEAR       = 2'd3
  } op_t;

  typedef enum logic {
    CFG_SPACE_MODE = 1'b0,
    CFG_PAIR_STEP  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] byte_in;
    sym_t       first_index;
    sym_t       second_index;
  } in_item_t;

  typedef struct packed {
    out_count_t count_value;
    out_count_t total_symbols;
    out_count_t total_pairs;
    sym_t       symbol_index;
    logic       symbol_valid;
    logic       saturated;
  } out_item_t;

  typedef struct packed {
    logic is_letter;
    sym_t idx;
  } fold_t;

  // Map a cp1251 byte onto a letter index 0..30.
  function automatic fold_t fold_letter(input logic [7:0] b);
    fold_t f;
    sym_t  o;
    o           = b[SYM_W-1:0];
    f.is_letter = 1'b1;
    f.idx       = o;
    if (b == BYTE_YO_UPPER || b == BYTE_YO_LOWER) begin
      f.idx = SYM_IE;
    end else if (b < BYTE_LETTER_LO) begin
      f.is_letter = 1'b0;
      f.idx       = '0;
    end else if (o == HARD_SIGN_POS) begin
      f.idx = SYM_SOFT_SIGN;
    end else if (o > HARD_SIGN_POS) begin
      f.idx = o - sym_t'(1);
    end
    return f;
  endfunction

  // Saturating increment.
  function automatic count_t cnt_inc(input count_t c);
    if (c == COUNT_MAX) begin
      return c;
    end
    return c + count_t'(1);
  endfunction

  // True when an increment leaves the counter at its maximum.
  function automatic logic cnt_hits_max(input count_t c);
    return (c == COUNT_MAX) || (c == COUNT_MAX - count_t'(1));
  endfunction

  // Low bits of a count in result-field width, zero-extended if narrower.
  function automatic out_count_t to_out(input count_t c);
    logic [OUT_WIDTH+COUNT_WIDTH-1:0] w;
    w = {{OUT_WIDTH{1'b0}}, c};
    return w[OUT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/lbfc_in_if.sv =====
// ============================================================================
// lbfc_in_if
// Input item channel: valid/ready handshake with an in_item_t payload.
// ============================================================================
`default_nettype none

interface lbfc_in_if;
  logic               valid;
  logic               ready;
  lbfc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/lbfc_out_if.sv =====
// ============================================================================
// lbfc_out_if
// Result channel: valid/ready handshake with an out_item_t payload.
// ============================================================================
`default_nettype none

interface lbfc_out_if;
  logic                valid;
  logic                ready;
  lbfc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/lbfc_cfg_if.sv =====
// ============================================================================
// lbfc_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
`default_nettype none

interface lbfc_cfg_if;
  logic                valid;
  logic                ready;
  lbfc_pkg::cfg_idx_t  index;
  logic [1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/lbfc_ram.sv =====
// ============================================================================
// lbfc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
`default_nettype none

module lbfc_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-before-write on an address collision.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/letter_bigram_frequency_counter.sv =====
// ============================================================================
// letter_bigram_frequency_counter
// Folds cp1251 bytes into 32 symbols and keeps letter and pair histograms.
// ============================================================================
// Result path: an input transfer loads S1, and S1 then loads the result register.
// Throughput: one item per cycle unless the output stalls or a clearing pass runs; the
//   counter RAMs do read-modify-write with one-deep forwarding from the write stage,
//   so back-to-back hits are exact.
// Reset: a clearing pass writes zero to all 1024 pair entries (and the 32 letter entries
//   alongside) with in_bus.ready low; a clear operation starts the same pass after its transfer.
// ============================================================================
`default_nettype none

module letter_bigram_frequency_counter (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lbfc_in_if.sink     in_bus,
  lbfc_out_if.source  out_bus,
  lbfc_cfg_if.sink    cfg_bus
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic       space_mode_r;
  logic [1:0] pair_step_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_mode_r <= 1'b1;
      pair_step_r  <= 2'd1;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        lbfc_pkg::CFG_SPACE_MODE: space_mode_r <= cfg_bus.data[0];
        lbfc_pkg::CFG_PAIR_STEP:  pair_step_r  <= cfg_bus.data;
        default:                  ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  //   S0: transfer, fold, update sequence state and totals, issue RAM reads
  //   S1: RAM data back, forward, bump, write back, build result
  //   out register: holds the result until the sink takes it
  // --------------------------------------------------------------------------
  logic sweep_active_r;
  logic s1_valid_r;
  logic out_valid_r;
  logic out_free;
  logic s1_move;
  logic in_xfer;

  assign out_free      = !out_valid_r || out_bus.ready;
  assign s1_move       = s1_valid_r && out_free;
  assign in_bus.ready  = !sweep_active_r && (!s1_valid_r || out_free);
  assign in_xfer       = in_bus.valid && in_bus.ready;

  // --------------------------------------------------------------------------
  // S0: symbol folding and sequence state
  // --------------------------------------------------------------------------
  lbfc_pkg::in_item_t in_item;
  lbfc_pkg::fold_t    fold;
  lbfc_pkg::sym_t     s0_sym;
  logic               s0_sym_ok;
  logic               s0_feed;
  logic               s0_form;
  logic               s0_tot_evt;

  lbfc_pkg::count_t   sym_total_r, sym_total_nxt;
  lbfc_pkg::count_t   pair_total_r, pair_total_nxt;
  lbfc_pkg::sym_t     prev_sym_r, prev_sym_nxt;
  logic               prev_valid_r, prev_valid_nxt;
  logic               phase_r, phase_nxt;

  assign in_item = in_bus.data;
  assign fold    = lbfc_pkg::fold_letter(in_item.byte_in);

  always_comb begin
    s0_sym    = '0;
    s0_sym_ok = 1'b0;
    if (fold.is_letter) begin
      s0_sym    = fold.idx;
      s0_sym_ok = 1'b1;
    end else if (space_mode_r &&
                 !(prev_valid_r && prev_sym_r == lbfc_pkg::SYM_SPACE)) begin
      // non-letter: one space per run, nothing if the last symbol was space
      s0_sym    = lbfc_pkg::SYM_SPACE;
      s0_sym_ok = 1'b1;
    end
  end

  assign s0_feed = (in_item.operation == lbfc_pkg::OP_FEED) && s0_sym_ok;

  // disjoint mode pairs only on the second symbol of each phase pair
  assign s0_form = (pair_step_r == lbfc_pkg::PAIR_STEP_DISJOINT) ?
                   (phase_r && prev_valid_r) : prev_valid_r;

  assign s0_tot_evt = s0_feed &&
                      (lbfc_pkg::cnt_hits_max(sym_total_r) ||
                       (s0_form && lbfc_pkg::cnt_hits_max(pair_total_r)));

  always_comb begin
    sym_total_nxt  = sym_total_r;
    pair_total_nxt = pair_total_r;
    prev_sym_nxt   = prev_sym_r;
    prev_valid_nxt = prev_valid_r;
    phase_nxt      = phase_r;
    if (in_xfer) begin
      case (in_item.operation)
        lbfc_pkg::OP_FEED: begin
          if (s0_sym_ok) begin
            sym_total_nxt = lbfc_pkg::cnt_inc(sym_total_r);
            if (s0_form) begin
              pair_total_nxt = lbfc_pkg::cnt_inc(pair_total_r);
            end
            phase_nxt      = !phase_r;
            prev_sym_nxt   = s0_sym;
            prev_valid_nxt = 1'b1;
          end
        end
        lbfc_pkg::OP_CLEAR: begin
          sym_total_nxt  = '0;
          pair_total_nxt = '0;
          prev_sym_nxt   = '0;
          prev_valid_nxt = 1'b0;
          phase_nxt      = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_total_r  <= '0;
      pair_total_r <= '0;
      prev_sym_r   <= '0;
      prev_valid_r <= 1'b0;
      phase_r      <= 1'b0;
    end else begin
      sym_total_r  <= sym_total_nxt;
      pair_total_r <= pair_total_nxt;
      prev_sym_r   <= prev_sym_nxt;
      prev_valid_r <= prev_valid_nxt;
      phase_r      <= phase_nxt;
    end
  end

  // RAM read addresses: the counted entry for a feed, the queried one for reads
  lbfc_pkg::sym_t       l_raddr;
  lbfc_pkg::pair_addr_t p_raddr;

  assign l_raddr = (in_item.operation == lbfc_pkg::OP_FEED) ? s0_sym :
                   in_item.first_index;
  assign p_raddr = (in_item.operation == lbfc_pkg::OP_FEED) ? {prev_sym_r, s0_sym} :
                   {in_item.first_index, in_item.second_index};

  // --------------------------------------------------------------------------
  // S1 registers (payload; only s1_valid_r is reset)
  // --------------------------------------------------------------------------
  lbfc_pkg::op_t        s1_op_r;
  lbfc_pkg::sym_t       s1_sym_r;
  logic                 s1_sym_ok_r;
  logic                 s1_form_r;
  logic                 s1_tot_evt_r;
  lbfc_pkg::sym_t       s1_l_addr_r;
  lbfc_pkg::pair_addr_t s1_p_addr_r;
  lbfc_pkg::count_t     s1_sym_total_r;
  lbfc_pkg::count_t     s1_pair_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r         <= in_item.operation;
      s1_sym_r        <= s0_feed ? s0_sym : '0;
      s1_sym_ok_r     <= s0_feed;
      s1_form_r       <= s0_feed && s0_form;
      s1_tot_evt_r    <= s0_tot_evt;
      s1_l_addr_r     <= l_raddr;
      s1_p_addr_r     <= p_raddr;
      s1_sym_total_r  <= sym_total_nxt;
      s1_pair_total_r <= pair_total_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Counter RAMs
  // --------------------------------------------------------------------------
  logic                 l_we, p_we;
  lbfc_pkg::sym_t       l_waddr;
  lbfc_pkg::pair_addr_t p_waddr;
  lbfc_pkg::count_t     l_wdata, p_wdata;
  lbfc_pkg::count_t     l_rdata, p_rdata;

  lbfc_ram #(
    .DATA_W (lbfc_pkg::COUNT_WIDTH),
    .ADDR_W (lbfc_pkg::SYM_W)
  ) u_letter_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (in_xfer),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  lbfc_ram #(
    .DATA_W (lbfc_pkg::COUNT_WIDTH),
    .ADDR_W (lbfc_pkg::PAIR_ADDR_W)
  ) u_pair_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (in_xfer),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // --------------------------------------------------------------------------
  // S1: forwarding and saturating bump
  //   The RAM returns old data when the write stage hits the same entry on the
  //   edge of the read, so the last write is kept and matched by address.
  // --------------------------------------------------------------------------
  logic                 fwd_l_valid_r, fwd_p_valid_r;
  lbfc_pkg::sym_t       fwd_l_addr_r;
  lbfc_pkg::pair_addr_t fwd_p_addr_r;
  lbfc_pkg::count_t     fwd_l_data_r, fwd_p_data_r;

  lbfc_pkg::count_t l_cur, p_cur, l_new, p_new;
  logic             s1_feed_l, s1_feed_p;
  logic             s1_sat_evt;

  assign l_cur = (fwd_l_valid_r && fwd_l_addr_r == s1_l_addr_r) ? fwd_l_data_r : l_rdata;
  assign p_cur = (fwd_p_valid_r && fwd_p_addr_r == s1_p_addr_r) ? fwd_p_data_r : p_rdata;
  assign l_new = lbfc_pkg::cnt_inc(l_cur);
  assign p_new = lbfc_pkg::cnt_inc(p_cur);

  assign s1_feed_l = s1_move && s1_sym_ok_r;
  assign s1_feed_p = s1_move && s1_form_r;

  assign s1_sat_evt = s1_tot_evt_r ||
                      (s1_sym_ok_r && lbfc_pkg::cnt_hits_max(l_cur)) ||
                      (s1_form_r && lbfc_pkg::cnt_hits_max(p_cur));

  // --------------------------------------------------------------------------
  // Clearing pass: sweeps every pair entry; letter entries ride on low bits
  // --------------------------------------------------------------------------
  lbfc_pkg::pair_addr_t sweep_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_active_r <= 1'b1;
      sweep_cnt_r    <= '0;
    end else if (in_xfer && in_item.operation == lbfc_pkg::OP_CLEAR) begin
      sweep_active_r <= 1'b1;
      sweep_cnt_r    <= '0;
    end else if (sweep_active_r) begin
      sweep_cnt_r <= sweep_cnt_r + lbfc_pkg::pair_addr_t'(1);
      if (&sweep_cnt_r) begin
        sweep_active_r <= 1'b0;
      end
    end
  end

  // Write port muxing; a sweep and a write-back never fall in the same cycle
  always_comb begin
    if (sweep_active_r) begin
      l_we    = 1'b1;
      l_waddr = sweep_cnt_r[lbfc_pkg::SYM_W-1:0];
      l_wdata = '0;
      p_we    = 1'b1;
      p_waddr = sweep_cnt_r;
      p_wdata = '0;
    end else begin
      l_we    = s1_feed_l;
      l_waddr = s1_l_addr_r;
      l_wdata = l_new;
      p_we    = s1_feed_p;
      p_waddr = s1_p_addr_r;
      p_wdata = p_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_l_valid_r <= 1'b0;
      fwd_p_valid_r <= 1'b0;
    end else if (sweep_active_r) begin
      fwd_l_valid_r <= 1'b0;
      fwd_p_valid_r <= 1'b0;
    end else begin
      if (s1_feed_l) begin
        fwd_l_valid_r <= 1'b1;
      end
      if (s1_feed_p) begin
        fwd_p_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_feed_l) begin
      fwd_l_addr_r <= s1_l_addr_r;
      fwd_l_data_r <= l_new;
    end
    if (s1_feed_p) begin
      fwd_p_addr_r <= s1_p_addr_r;
      fwd_p_data_r <= p_new;
    end
  end

  // --------------------------------------------------------------------------
  // Saturation flag, kept in result order at S1
  // --------------------------------------------------------------------------
  logic sat_r, sat_nxt;

  always_comb begin
    sat_nxt = sat_r;
    if (s1_move) begin
      if (s1_op_r == lbfc_pkg::OP_CLEAR) begin
        sat_nxt = 1'b0;
      end else begin
        sat_nxt = sat_r || s1_sat_evt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else begin
      sat_r <= sat_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  lbfc_pkg::out_item_t out_data_r, out_data_nxt;
  lbfc_pkg::count_t    s1_count;

  always_comb begin
    case (s1_op_r)
      lbfc_pkg::OP_READ_LETTER: s1_count = l_cur;
      lbfc_pkg::OP_READ_PAIR:   s1_count = p_cur;
      default:                  s1_count = '0;
    endcase
  end

  always_comb begin
    out_data_nxt.count_value   = lbfc_pkg::to_out(s1_count);
    out_data_nxt.total_symbols = lbfc_pkg::to_out(s1_sym_total_r);
    out_data_nxt.total_pairs   = lbfc_pkg::to_out(s1_pair_total_r);
    out_data_nxt.symbol_index  = s1_sym_r;
    out_data_nxt.symbol_valid  = s1_sym_ok_r;
    out_data_nxt.saturated     = sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

endmodule

`default_nettype wire

// ===== verif/letter_bigram_frequency_counter_tb.sv =====
// ============================================================================
// letter_bigram_frequency_counter_tb
// Self-checking bench: a scripted opening run, then randomized phases under
// several space/pair-step settings, each result checked against an in-bench
// model of the symbol and pair histograms.
// ============================================================================
module letter_bigram_frequency_counter_tb;
  import lbfc_pkg::*;

  // Sender gaps and receiver stalls are picked from the same spread: mostly
  // back to back, some short holes, now and then a long one.
  localparam int GAP_SHORT_MAX = 3;
  localparam int GAP_LONG_MIN  = 10;
  localparam int GAP_LONG_MAX  = 40;

  // Items per random phase and the per-phase register plan (phase p uses
  // SPACE_PLAN[p] and STEP_PLAN[2p+:2]). Steps 0 and 3 behave as overlapping.
  localparam int PHASE_ITEMS = 75;
  localparam int NUM_PHASES  = 6;
  localparam logic [5:0]  SPACE_PLAN = 6'b101001;
  localparam logic [11:0] STEP_PLAN  = {2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2};

  // Bytes that keep the random text on a small alphabet so the pair table
  // fills up in a few places: first letters, lower a, punctuation, YO, hard sign.
  localparam logic [79:0] HOT_BYTES =
    {8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hE0, 8'h20, 8'h2E, 8'hA8, 8'hDA, 8'hFA};

  // A clearing pass runs after reset and after every clear op; the whole run
  // stays well under this limit.
  localparam int RUN_LIMIT = 4_000_000;

  // Settle time before a register write or the end of the run.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;

  logic clk;
  logic rst_n;

  lbfc_in_if  in_bus();
  lbfc_out_if out_bus();
  lbfc_cfg_if cfg_bus();

  letter_bigram_frequency_counter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Histogram model: own copy of the registers and the counting state
  // --------------------------------------------------------------------------
  logic       mode_space = 1'b1;
  logic [1:0] step_sel   = 2'd1;

  count_t letter_hist [32];
  count_t pair_hist   [1024];
  count_t sym_total;
  count_t pair_total;
  sym_t   last_sym;
  logic   last_sym_ok;
  logic   half_pair;     // disjoint mode: high when the next symbol closes a pair
  logic   sat_seen;      // sticky until a clear

  // Results still owed by the block, oldest first.
  out_item_t awaited_results [$];

  int mismatch_count = 0;
  int result_seq     = 0;

  function automatic void clear_histograms();
    for (int i = 0; i < 32; i++) begin
      letter_hist[i] = '0;
    end
    for (int i = 0; i < 1024; i++) begin
      pair_hist[i] = '0;
    end
    sym_total   = '0;
    pair_total  = '0;
    last_sym    = '0;
    last_sym_ok = 1'b0;
    half_pair   = 1'b0;
    sat_seen    = 1'b0;
  endfunction

  // Saturating count; reaching or sitting at the top sets the sticky flag.
  function automatic count_t sat_bump(input count_t v);
    if (v == COUNT_MAX) begin
      sat_seen = 1'b1;
      return v;
    end
    if (v == COUNT_MAX - count_t'(1)) begin
      sat_seen = 1'b1;
    end
    return v + count_t'(1);
  endfunction

  // cp1251 byte to letter index; bit 5 set means not a letter.
  function automatic logic [5:0] fold_cp1251(input logic [7:0] b);
    if (b == BYTE_YO_UPPER || b == BYTE_YO_LOWER) begin
      return {1'b0, SYM_IE};
    end
    if (b < BYTE_LETTER_LO) begin
      return 6'b10_0000;
    end
    if (b[4:0] < HARD_SIGN_POS) begin
      return {1'b0, b[4:0]};
    end
    if (b[4:0] == HARD_SIGN_POS) begin
      return {1'b0, SYM_SOFT_SIGN};
    end
    return {1'b0, b[4:0] - 5'd1};
  endfunction

  // Advance the model by one item and return the result it owes.
  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t  r;
    logic [5:0] folded;
    sym_t       s;
    logic       took;
    logic       closes_pair;
    pair_addr_t slot;
    r    = '0;
    took = 1'b0;
    s    = '0;
    case (it.operation)
      OP_FEED: begin
        folded = fold_cp1251(it.byte_in);
        if (!folded[5]) begin
          s    = folded[4:0];
          took = 1'b1;
        end else if (mode_space && !(last_sym_ok && last_sym == SYM_SPACE)) begin
          // non-letter becomes one space; a run of them collapses
          s    = SYM_SPACE;
          took = 1'b1;
        end
        if (took) begin
          letter_hist[s] = sat_bump(letter_hist[s]);
          sym_total      = sat_bump(sym_total);
          if (step_sel == PAIR_STEP_DISJOINT) begin
            closes_pair = half_pair && last_sym_ok;
          end else begin
            closes_pair = last_sym_ok;
          end
          if (closes_pair) begin
            slot            = {last_sym, s};
            pair_hist[slot] = sat_bump(pair_hist[slot]);
            pair_total      = sat_bump(pair_total);
          end
          half_pair       = ~half_pair;
          last_sym        = s;
          last_sym_ok     = 1'b1;
          r.symbol_index  = s;
          r.symbol_valid  = 1'b1;
        end
      end
      OP_READ_LETTER: begin
        r.count_value = out_count_t'(letter_hist[it.first_index]);
      end
      OP_READ_PAIR: begin
        r.count_value = out_count_t'(pair_hist[{it.first_index, it.second_index}]);
      end
      default: begin
        clear_histograms();
      end
    endcase
    r.total_symbols = out_count_t'(sym_total);
    r.total_pairs   = out_count_t'(pair_total);
    r.saturated     = sat_seen;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // keep the log readable if everything goes wrong
    if (mismatch_count < 100) begin
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $realtime, result_seq, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic compare_result(input out_item_t got, input out_item_t want);
    if (got.count_value !== want.count_value) begin
      report_mismatch("count_value", 32'(got.count_value), 32'(want.count_value));
    end
    if (got.total_symbols !== want.total_symbols) begin
      report_mismatch("total_symbols", 32'(got.total_symbols), 32'(want.total_symbols));
    end
    if (got.total_pairs !== want.total_pairs) begin
      report_mismatch("total_pairs", 32'(got.total_pairs), 32'(want.total_pairs));
    end
    if (got.symbol_index !== want.symbol_index) begin
      report_mismatch("symbol_index", 32'(got.symbol_index), 32'(want.symbol_index));
    end
    if (got.symbol_valid !== want.symbol_valid) begin
      report_mismatch("symbol_valid", 32'(got.symbol_valid), 32'(want.symbol_valid));
    end
    if (got.saturated !== want.saturated) begin
      report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
    end
  endtask

  // Outputs are sampled at the edge, before any update scheduled for it.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_bus.data.count_value), 0);
      end else begin
        compare_result(out_bus.data, awaited_results.pop_front());
      end
      result_seq++;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, GAP_SHORT_MAX);
    end
    return $urandom_range(GAP_LONG_MIN, GAP_LONG_MAX);
  endfunction

  int unsigned ready_left = 0;

  // Mix ready-high stretches, picked at random, with stalls of the
  // sender-gap spread, so stalls land on every phase of the pipeline.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_bus.ready <= 1'b0;
        ready_left = 1 + pick_gap();
      end else begin
        out_bus.ready <= 1'b1;
        ready_left = $urandom_range(1, 20);
      end
    end else begin
      ready_left--;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Holds valid until the transfer; valid stays up afterwards, the caller
  // drops it when a gap, a pause, a register write or the end follows.
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    in_bus.valid <= 1'b1;
    in_bus.data  <= it;
    do begin
      @(posedge clk);
    end while (in_bus.ready !== 1'b1);
    predicted = predict_result(it);
    awaited_results.insert(awaited_results.size(), typed ? want : predicted);
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Register writes only happen with the block idle: nothing pending, then
  // SETTLE_CYCLES of settle time for the pipeline to empty.
  task automatic write_register(input cfg_idx_t sel, input logic [1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= sel;
    cfg_bus.data  <= val;
    do begin
      @(posedge clk);
    end while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    if (sel == CFG_SPACE_MODE) begin
      mode_space = val[0];
    end else begin
      step_sel = val;
    end
  endtask

  // --------------------------------------------------------------------------
  // Scripted opening run
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic      cfg_write;
    cfg_idx_t  reg_sel;
    logic [1:0] reg_val;
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } script_row_t;

  script_row_t script [$];

  function automatic void add_item(input op_t op, input logic [7:0] b, input sym_t fi,
                                   input sym_t si, input logic typed,
                                   input out_item_t want);
    script_row_t row;
    row                   = '0;
    row.item.operation    = op;
    row.item.byte_in      = b;
    row.item.first_index  = fi;
    row.item.second_index = si;
    row.typed             = typed;
    row.want              = want;
    script.insert(script.size(), row);
  endfunction

  function automatic void add_cfg(input cfg_idx_t sel, input logic [1:0] val);
    script_row_t row;
    row           = '0;
    row.cfg_write = 1'b1;
    row.reg_sel   = sel;
    row.reg_val   = val;
    script.insert(script.size(), row);
  endfunction

  function automatic out_item_t result_of(input int count, input int syms, input int pairs,
                                          input int sym, input logic ok);
    out_item_t r;
    r.count_value   = out_count_t'(count);
    r.total_symbols = out_count_t'(syms);
    r.total_pairs   = out_count_t'(pairs);
    r.symbol_index  = sym_t'(sym);
    r.symbol_valid  = ok;
    r.saturated     = 1'b0;
    return r;
  endfunction

  function automatic void build_script();
    // defaults written explicitly, while the reset clearing pass still runs
    add_cfg(CFG_SPACE_MODE, 2'd1);
    add_cfg(CFG_PAIR_STEP, 2'd1);
    // empty stores after reset, lowest and highest indices
    add_item(OP_READ_LETTER, 8'h00, 0, 0, 1'b1, result_of(0, 0, 0, 0, 1'b0));
    add_item(OP_READ_PAIR, 8'hFF, 31, 31, 1'b1, result_of(0, 0, 0, 0, 1'b0));
    // start of text: a non-letter yields one space, no pair
    add_item(OP_FEED, 8'h41, 0, 0, 1'b1, result_of(0, 1, 0, SYM_SPACE, 1'b1));
    // second non-letter collapses into the same space
    add_item(OP_FEED, 8'h20, 0, 0, 1'b1, result_of(0, 1, 0, 0, 1'b0));
    // first letter, pairs with the space
    add_item(OP_FEED, 8'hC0, 0, 0, 1'b1, result_of(0, 2, 1, 0, 1'b1));
    add_item(OP_FEED, 8'hFF, 0, 0, 1'b0, '0);  // last lower letter
    add_item(OP_FEED, 8'hA8, 0, 0, 1'b0, '0);  // YO folds into IE
    add_item(OP_FEED, 8'hB8, 0, 0, 1'b0, '0);
    add_item(OP_FEED, 8'hDA, 0, 0, 1'b0, '0);  // hard sign folds into soft sign
    add_item(OP_FEED, 8'hFA, 0, 0, 1'b0, '0);
    add_item(OP_FEED, 8'hDF, 0, 0, 1'b0, '0);  // last upper letter
    add_item(OP_FEED, 8'hE0, 0, 0, 1'b0, '0);
    add_item(OP_FEED, 8'hBF, 0, 0, 1'b0, '0);  // just below the letter range
    add_item(OP_FEED, 8'h00, 0, 0, 1'b0, '0);  // collapses
    add_item(OP_READ_LETTER, 8'h00, SYM_IE, 0, 1'b0, '0);
    add_item(OP_READ_LETTER, 8'h00, SYM_SOFT_SIGN, 0, 1'b0, '0);
    add_item(OP_READ_LETTER, 8'h00, SYM_SPACE, 0, 1'b0, '0);
    add_item(OP_READ_PAIR, 8'h00, SYM_IE, SYM_IE, 1'b0, '0);
    add_item(OP_READ_PAIR, 8'h00, SYM_SPACE, 0, 1'b0, '0);
    // clear wipes counts and totals, registers stay
    add_item(OP_CLEAR, 8'h00, 0, 0, 1'b1, result_of(0, 0, 0, 0, 1'b0));
    add_item(OP_READ_PAIR, 8'h00, SYM_SPACE, 0, 1'b1, result_of(0, 0, 0, 0, 1'b0));
    // disjoint pairs: second symbol closes a pair, a trailing odd one does not
    add_cfg(CFG_PAIR_STEP, PAIR_STEP_DISJOINT);
    add_item(OP_FEED, 8'hC1, 0, 0, 1'b1, result_of(0, 1, 0, 1, 1'b1));
    add_item(OP_FEED, 8'hC2, 0, 0, 1'b1, result_of(0, 2, 1, 2, 1'b1));
    add_item(OP_FEED, 8'hC3, 0, 0, 1'b1, result_of(0, 3, 1, 3, 1'b1));
    // space mode off: non-letters are dropped
    add_cfg(CFG_SPACE_MODE, 2'd0);
    add_item(OP_FEED, 8'h20, 0, 0, 1'b1, result_of(0, 3, 1, 0, 1'b0));
    add_item(OP_FEED, 8'hC4, 0, 0, 1'b0, '0);
    add_item(OP_READ_PAIR, 8'h00, 1, 2, 1'b0, '0);
    add_item(OP_READ_PAIR, 8'h00, 3, 4, 1'b0, '0);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_item_t it;
    int       gap;
    int       r;
    logic     quiet;
    logic     pause;
    logic     drop_valid;

    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_SPACE_MODE;
    cfg_bus.data  = '0;
    out_bus.ready = 1'b0;
    clear_histograms();
    build_script();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Scripted part: valid drops before a register write, on random gaps and after the last item.
    for (int i = 0; i < script.size(); i++) begin
      if (script[i].cfg_write) begin
        write_register(script[i].reg_sel, script[i].reg_val);
      end else begin
        send_item(script[i].item, script[i].typed, script[i].want);
        gap        = pick_gap();
        drop_valid = (gap > 0) || (i + 1 == script.size()) || script[i + 1].cfg_write;
        if (drop_valid) begin
          in_bus.valid <= 1'b0;
        end
        repeat (gap) @(posedge clk);
      end
    end

    // Random phases, one register setting each. Some phases run without any
    // sender gaps; the first phase always pauses until the block has drained.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(CFG_SPACE_MODE, {1'($urandom_range(0, 1)), SPACE_PLAN[p]});
      write_register(CFG_PAIR_STEP, STEP_PLAN[2*p +: 2]);
      quiet = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.byte_in      = 8'($urandom_range(0, 255));
        it.first_index  = sym_t'($urandom_range(0, 31));
        it.second_index = sym_t'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        if (r < 70) begin
          it.operation = OP_FEED;
          case ($urandom_range(0, 9))
            0, 1, 2, 3: it.byte_in = HOT_BYTES[8*$urandom_range(0, 9) +: 8];
            4, 5, 6:    it.byte_in = 8'($urandom_range(8'hC0, 8'hFF));
            default:    ;
          endcase
        end else if (r < 98) begin
          it.operation = (r < 84) ? OP_READ_LETTER : OP_READ_PAIR;
          // aim most reads at entries that are likely to be non-zero
          case ($urandom_range(0, 3))
            0:       ;
            1:       it.first_index = sym_t'($urandom_range(0, 3));
            2:       it.first_index = SYM_SPACE;
            default: it.first_index = last_sym;
          endcase
          if ($urandom_range(0, 1) == 1) begin
            it.second_index = sym_t'($urandom_range(0, 3));
          end
        end else begin
          it.operation = OP_CLEAR;
        end

        send_item(it, 1'b0, '0);
        gap   = quiet ? 0 : pick_gap();
        pause = ($urandom_range(0, 99) < 2) || (p == 0 && n == PHASE_ITEMS / 2);
        if (gap > 0 || pause || n == PHASE_ITEMS - 1) begin
          in_bus.valid <= 1'b0;
        end
        repeat (gap) @(posedge clk);
        if (pause) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** letter_bigram_frequency_counter: PASSED **");
    end else begin
      $display("** letter_bigram_frequency_counter: FAILED **");
    end
    $finish;
  end

  // Hang guard: a stuck handshake or a missing result ends up here.
  initial begin
    #RUN_LIMIT;
    $display("** letter_bigram_frequency_counter: FAILED **");
    $finish;
  end

endmodule
